[hdl/vrle_pkg.sv]
// Shared types and constants for the register-log encoder.
// Used by vrle_front, vrle_queue, vrle_back and the top level.
// No dependencies.
package vrle_pkg;

  // Field widths
  localparam int STAMP_W   = 48;
  localparam int SAMPLE_W  = 42;
  localparam int ADDR_W    = 16;
  localparam int TOTAL_W   = 32;
  localparam int HALF_W    = STAMP_W / 2;
  localparam int PROD_W    = HALF_W + 16;
  localparam int SUM_W     = 64;

  // Clock-to-sample conversion: (cycles * 44100) >> 22
  localparam logic [15:0] RATE_HZ     = 16'd44100;
  localparam int          CLOCK_SHIFT = 22;

  // Command opcodes
  localparam logic [7:0] CMD_WAIT  = 8'h61;
  localparam logic [7:0] CMD_SHORT = 8'h70;
  localparam logic [7:0] CMD_END   = 8'h66;
  localparam logic [7:0] CMD_REG   = 8'hb3;

  // Byte counts per command
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_THREE = 2'd3;

  localparam logic [15:0]         CHUNK_MAX   = 16'hffff;
  localparam logic [SAMPLE_W-1:0] SHORT_LIMIT = SAMPLE_W'(17);
  localparam logic [ADDR_W-1:0]   REG_BASE    = 16'hff10;

  // Queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item, ready for the back end
  typedef struct packed {
    logic                op_finish;
    logic [SAMPLE_W-1:0] delay;
    logic                has_reg;
    logic [7:0]          reg_idx;
    logic [7:0]          reg_val;
    logic [TOTAL_W-1:0]  total;
  } entry_t;

  // Queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/vgm_register_log_encoder_core.sv]
// Register-log encoder: timestamped register writes in, command beats out.
// The front captures the beat, forms two 24x16 products, sums them and
// classifies the item; the queue holds it, the back end loads it and then emits
// one command beat per cycle while the output slot is free. The front takes no
// new beat until the last is classified; the back end loads one item at a time.
// Reset (rst_n low, synchronous) clears the sample position, queue and sequencers.
module vgm_register_log_encoder_core #(
  parameter int MAX_WAIT_CHUNKS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // cycle_stamp[47:0], reg_addr[63:48], reg_value[71:64]
  input  logic        in_tuser,   // op: 0 register write, 1 finish
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // cmd_byte[7:0], arg_one[15:8], arg_two[23:16],
                                  // byte_count[25:24], sample_total[57:26], zero
  output logic        out_tlast
);

  vrle_pkg::q_stat_t q_stat;
  vrle_pkg::entry_t  push_entry;
  vrle_pkg::entry_t  head;
  logic              push;
  logic              pop;

  vrle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  vrle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  vrle_back #(
    .MAX_WAIT_CHUNKS (MAX_WAIT_CHUNKS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/vrle_front.sv]
// Front end: accepts input beats, converts the stamp to samples and
// classifies the item into a queue entry. Owns the emitted sample position.
// Depends on vrle_pkg.
module vrle_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,
  input  logic                  in_tuser,
  input  vrle_pkg::q_stat_t     q_stat,
  output logic                  push,
  output vrle_pkg::entry_t      push_entry
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;
  localparam logic [1:0] F_DIFF = 2'd3;

  logic [1:0]                      st_r, st_nxt;
  logic                            op_r;
  logic [vrle_pkg::STAMP_W-1:0]    stamp_r;
  logic [vrle_pkg::ADDR_W-1:0]     addr_r;
  logic [7:0]                      val_r;
  logic [vrle_pkg::PROD_W-1:0]     plo_r, phi_r;
  logic [vrle_pkg::SAMPLE_W-1:0]   now_r;
  logic [vrle_pkg::SAMPLE_W-1:0]   emitted_r, emitted_nxt;
  logic [vrle_pkg::SUM_W-1:0]      sum;
  logic [vrle_pkg::SAMPLE_W-1:0]   delay;
  logic                            has_reg;
  logic                            need_push;
  logic                            done;

  assign in_tready = (st_r == F_IDLE);

  // Recombine the two partial products
  assign sum = {{(vrle_pkg::SUM_W - vrle_pkg::PROD_W){1'b0}}, plo_r}
             + {phi_r, {(vrle_pkg::SUM_W - vrle_pkg::PROD_W){1'b0}}};

  // Delay since the last event; a backward stamp gives none
  assign delay   = (now_r > emitted_r) ? (now_r - emitted_r) : '0;
  assign has_reg = (addr_r >= vrle_pkg::REG_BASE);

  assign need_push = op_r || (delay != '0) || has_reg;
  assign push      = (st_r == F_DIFF) && need_push && !q_stat.full;
  assign done      = (st_r == F_DIFF) && (!need_push || !q_stat.full);

  always_comb begin
    push_entry.op_finish = op_r;
    push_entry.delay     = op_r ? '0 : delay;
    push_entry.has_reg   = !op_r && has_reg;
    push_entry.reg_idx   = addr_r[7:0] - vrle_pkg::REG_BASE[7:0];
    push_entry.reg_val   = val_r;
    push_entry.total     = emitted_r[vrle_pkg::TOTAL_W-1:0];
  end

  // Sequencer
  always_comb begin
    st_nxt      = st_r;
    emitted_nxt = emitted_r;
    case (st_r)
      F_IDLE: if (in_tvalid) st_nxt = F_MUL;
      F_MUL:  st_nxt = F_SUM;
      F_SUM:  st_nxt = F_DIFF;
      F_DIFF: begin
        if (done) begin
          st_nxt      = F_IDLE;
          emitted_nxt = op_r ? '0 : now_r;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= F_IDLE;
      emitted_r <= '0;
    end else begin
      st_r      <= st_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  // Datapath: capture, two 24x16 products, then the shifted sum
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stamp_r <= in_tdata[vrle_pkg::STAMP_W-1:0];
      addr_r  <= in_tdata[63:48];
      val_r   <= in_tdata[71:64];
      op_r    <= in_tuser;
    end
    if (st_r == F_MUL) begin
      plo_r <= stamp_r[vrle_pkg::HALF_W-1:0] * vrle_pkg::RATE_HZ;
      phi_r <= stamp_r[vrle_pkg::STAMP_W-1:vrle_pkg::HALF_W] * vrle_pkg::RATE_HZ;
    end
    if (st_r == F_SUM) begin
      now_r <= sum[vrle_pkg::SUM_W-1:vrle_pkg::CLOCK_SHIFT];
    end
  end

endmodule

[hdl/vrle_queue.sv]
// Short FIFO of classified items between the front and back ends.
// Depends on vrle_pkg.
module vrle_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vrle_pkg::entry_t   push_entry,
  input  logic               pop,
  output vrle_pkg::entry_t   head,
  output vrle_pkg::q_stat_t  q_stat
);

  vrle_pkg::entry_t               q_r [vrle_pkg::QUEUE_DEPTH];
  logic [vrle_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [vrle_pkg::QCNT_W-1:0]    count_r;

  assign q_stat.full  = (count_r == vrle_pkg::QCNT_W'(vrle_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = q_r[rd_ptr_r];

  // Pointers wrap naturally since the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_entry;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !pop) |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule

[hdl/vrle_back.sv]
// Back end: expands one queue entry into commands, one per cycle while the
// output slot is free, through a registered output stage. Depends on vrle_pkg.
module vrle_back #(
  parameter int MAX_WAIT_CHUNKS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vrle_pkg::entry_t   head,
  input  vrle_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  output logic               out_tlast
);

  localparam int CW = $clog2(MAX_WAIT_CHUNKS + 1);
  localparam logic [CW-1:0] CHUNK_LIMIT = CW'(MAX_WAIT_CHUNKS);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_WAIT = 3'd1;
  localparam logic [2:0] B_REG  = 3'd2;
  localparam logic [2:0] B_FIN1 = 3'd3;
  localparam logic [2:0] B_FIN2 = 3'd4;

  logic [2:0]                     st_r, st_nxt;
  logic [vrle_pkg::SAMPLE_W-1:0]  delay_r, delay_nxt;
  logic [CW-1:0]                  chunks_r, chunks_nxt;
  logic                           has_reg_r, has_reg_nxt;
  logic [7:0]                     idx_r, idx_nxt;
  logic [7:0]                     val_r, val_nxt;
  logic [vrle_pkg::TOTAL_W-1:0]   total_r, total_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [7:0]                     cmd_r, cmd_nxt;
  logic [7:0]                     a1_r, a1_nxt;
  logic [7:0]                     a2_r, a2_nxt;
  logic [1:0]                     cnt_r, cnt_nxt;
  logic [vrle_pkg::TOTAL_W-1:0]   tot_r, tot_nxt;
  logic                           last_r, last_nxt;

  logic                           slot_free;
  logic                           is_short;
  logic [15:0]                    chunk;
  logic [vrle_pkg::SAMPLE_W-1:0]  delay_after;
  logic [CW-1:0]                  chunk_inc;
  logic                           wait_end;

  assign slot_free = !out_valid_r || out_tready;
  assign pop       = (st_r == B_IDLE) && !q_stat.empty;

  // Next wait chunk from the remaining delay
  assign is_short    = (delay_r < vrle_pkg::SHORT_LIMIT);
  assign chunk       = (delay_r > vrle_pkg::SAMPLE_W'(vrle_pkg::CHUNK_MAX)) ?
                       vrle_pkg::CHUNK_MAX : delay_r[15:0];
  assign delay_after = is_short ? '0 : (delay_r - vrle_pkg::SAMPLE_W'(chunk));
  assign chunk_inc   = chunks_r + 1'b1;
  assign wait_end    = (delay_after == '0) || (chunk_inc == CHUNK_LIMIT);

  always_comb begin
    st_nxt        = st_r;
    delay_nxt     = delay_r;
    chunks_nxt    = chunks_r;
    has_reg_nxt   = has_reg_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd_nxt       = cmd_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    cnt_nxt       = cnt_r;
    tot_nxt       = tot_r;
    last_nxt      = last_r;
    case (st_r)
      // Load the next entry
      B_IDLE: begin
        if (!q_stat.empty) begin
          delay_nxt   = head.delay;
          chunks_nxt  = '0;
          has_reg_nxt = head.has_reg;
          idx_nxt     = head.reg_idx;
          val_nxt     = head.reg_val;
          total_nxt   = head.total;
          if (head.op_finish)          st_nxt = B_FIN1;
          else if (head.delay != '0)   st_nxt = B_WAIT;
          else                         st_nxt = B_REG;
        end
      end
      // One wait command per beat
      B_WAIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          tot_nxt       = '0;
          last_nxt      = wait_end && !has_reg_r;
          if (is_short) begin
            cmd_nxt = vrle_pkg::CMD_SHORT | {4'd0, delay_r[3:0] - 4'd1};
            a1_nxt  = '0;
            a2_nxt  = '0;
            cnt_nxt = vrle_pkg::CNT_ONE;
          end else begin
            cmd_nxt = vrle_pkg::CMD_WAIT;
            a1_nxt  = chunk[7:0];
            a2_nxt  = chunk[15:8];
            cnt_nxt = vrle_pkg::CNT_THREE;
          end
          delay_nxt  = delay_after;
          chunks_nxt = chunk_inc;
          if (wait_end) st_nxt = has_reg_r ? B_REG : B_IDLE;
        end
      end
      B_REG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          cmd_nxt       = vrle_pkg::CMD_REG;
          a1_nxt        = idx_r;
          a2_nxt        = val_r;
          cnt_nxt       = vrle_pkg::CNT_THREE;
          tot_nxt       = '0;
          last_nxt      = 1'b1;
          st_nxt        = B_IDLE;
        end
      end
      // Closing one-second wait
      B_FIN1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          cmd_nxt       = vrle_pkg::CMD_WAIT;
          a1_nxt        = vrle_pkg::RATE_HZ[7:0];
          a2_nxt        = vrle_pkg::RATE_HZ[15:8];
          cnt_nxt       = vrle_pkg::CNT_THREE;
          tot_nxt       = total_r;
          last_nxt      = 1'b0;
          st_nxt        = B_FIN2;
        end
      end
      // End marker
      B_FIN2: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          cmd_nxt       = vrle_pkg::CMD_END;
          a1_nxt        = '0;
          a2_nxt        = '0;
          cnt_nxt       = vrle_pkg::CNT_ONE;
          tot_nxt       = total_r;
          last_nxt      = 1'b1;
          st_nxt        = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      chunks_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      chunks_r    <= chunks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delay_r   <= delay_nxt;
    has_reg_r <= has_reg_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    total_r   <= total_nxt;
    cmd_r     <= cmd_nxt;
    a1_r      <= a1_nxt;
    a2_r      <= a2_nxt;
    cnt_r     <= cnt_nxt;
    tot_r     <= tot_nxt;
    last_r    <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0, tot_r, cnt_r, a2_r, a1_r, cmd_r};

`ifndef SYNTHESIS
  a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_WAIT) |-> (delay_r != '0)) else $error("wait state with no delay");
  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_WAIT) |-> (chunks_r < CHUNK_LIMIT)) else $error("wait chunk overrun");
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cmd_r == vrle_pkg::CMD_END)) |-> last_r)
    else $error("end marker without last");
`endif

endmodule

[verif/vgm_register_log_encoder_core_tb.sv]
// Self-checking testbench for vgm_register_log_encoder_core.
// Sends directed and random register-write / finish beats and checks every command beat
// against typed rows or a local encoder model. Depends on vrle_pkg and the core RTL only.
module vgm_register_log_encoder_core_tb;

  localparam int WAIT_CHUNK_LIMIT = 32;
  localparam int RANDOM_BEATS     = 460;
  localparam int CALM_BEATS       = 60;
  localparam int DRAIN_CYCLES     = 80;
  localparam int LIMIT_CYCLES     = 2_000_000;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // One command as it leaves the block
  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  arg1;
    logic [7:0]  arg2;
    logic [1:0]  nbytes;
    logic [31:0] total;
    logic        last;
  } vgm_cmd_t;

  // One directed beat; n_typed < 0 means the local model supplies the commands
  typedef struct {
    logic        op;
    logic [47:0] stamp;
    logic [15:0] addr;
    logic [7:0]  val;
    int          n_typed;
    vgm_cmd_t    t0;
    vgm_cmd_t    t1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  vgm_register_log_encoder_core #(
    .MAX_WAIT_CHUNKS(WAIT_CHUNK_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Model state and scoreboard
  logic [vrle_pkg::SAMPLE_W-1:0] sample_pos = '0;
  vgm_cmd_t            new_cmds[$];
  vgm_cmd_t            pending_cmds[$];
  stim_row_t           dir_rows[$];
  vgm_cmd_t            seen_cmd, want_cmd;
  bit                  calm = 1'b0;
  int                  err_count = 0;
  int                  beats_in = 0;
  int                  finish_beats = 0;
  int                  cmd_beats = 0;
  int                  clamped_writes = 0;
  int                  cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic vgm_cmd_t mk_cmd(input logic [7:0] cmd, input logic [7:0] arg1,
                                      input logic [7:0] arg2, input logic [1:0] nbytes,
                                      input logic [31:0] total, input logic last);
    vgm_cmd_t c;
    c.cmd    = cmd;
    c.arg1   = arg1;
    c.arg2   = arg2;
    c.nbytes = nbytes;
    c.total  = total;
    c.last   = last;
    return c;
  endfunction

  // Encoder model: fills new_cmds for one input beat and updates sample_pos
  function automatic void encode_beat(input logic op, input logic [47:0] stamp,
                                      input logic [15:0] addr, input logic [7:0] val);
    logic [63:0]                   scaled;
    logic [vrle_pkg::SAMPLE_W-1:0] now_pos;
    logic [vrle_pkg::SAMPLE_W-1:0] delay;
    logic [15:0]                   chunk;
    vgm_cmd_t                      tail;
    int                            nwaits;
    new_cmds.delete();
    if (op == OP_FINISH) begin
      new_cmds.push_back(mk_cmd(vrle_pkg::CMD_WAIT, vrle_pkg::RATE_HZ[7:0],
                                vrle_pkg::RATE_HZ[15:8], vrle_pkg::CNT_THREE,
                                sample_pos[31:0], 1'b0));
      new_cmds.push_back(mk_cmd(vrle_pkg::CMD_END, 8'h00, 8'h00, vrle_pkg::CNT_ONE,
                                sample_pos[31:0], 1'b0));
      sample_pos = '0;
    end else begin
      // exact cycles-to-samples conversion
      scaled  = {16'd0, stamp} * 64'(vrle_pkg::RATE_HZ);
      now_pos = scaled[63:vrle_pkg::CLOCK_SHIFT];
      delay   = (now_pos > sample_pos) ? now_pos - sample_pos : '0;
      nwaits  = 0;
      while (delay != '0 && nwaits < WAIT_CHUNK_LIMIT) begin
        if (delay < vrle_pkg::SHORT_LIMIT) begin
          new_cmds.push_back(mk_cmd(vrle_pkg::CMD_SHORT | 8'(delay - 1), 8'h00, 8'h00,
                                    vrle_pkg::CNT_ONE, 32'd0, 1'b0));
          delay = '0;
        end else begin
          chunk = (delay > vrle_pkg::SAMPLE_W'(vrle_pkg::CHUNK_MAX)) ?
                  vrle_pkg::CHUNK_MAX : delay[15:0];
          new_cmds.push_back(mk_cmd(vrle_pkg::CMD_WAIT, chunk[7:0], chunk[15:8],
                                    vrle_pkg::CNT_THREE, 32'd0, 1'b0));
          delay = delay - vrle_pkg::SAMPLE_W'(chunk);
        end
        nwaits++;
      end
      if (delay != '0)
        clamped_writes++;
      if (addr >= vrle_pkg::REG_BASE)
        new_cmds.push_back(mk_cmd(vrle_pkg::CMD_REG, 8'(addr - vrle_pkg::REG_BASE), val,
                                  vrle_pkg::CNT_THREE, 32'd0, 1'b0));
      sample_pos = now_pos;
    end
    // flag the final command of this beat
    if (new_cmds.size() != 0) begin
      tail = new_cmds.pop_back();
      tail.last = 1'b1;
      new_cmds.push_back(tail);
    end
  endfunction

  task automatic add_row(input logic op, input logic [47:0] stamp, input logic [15:0] addr,
                         input logic [7:0] val, input int n_typed, input vgm_cmd_t t0,
                         input vgm_cmd_t t1);
    stim_row_t r;
    r.op      = op;
    r.stamp   = stamp;
    r.addr    = addr;
    r.val     = val;
    r.n_typed = n_typed;
    r.t0      = t0;
    r.t1      = t1;
    dir_rows.push_back(r);
  endtask

  // Drive one input beat and hold it until accepted; tvalid stays high on return
  task automatic send_beat(input logic op, input logic [47:0] stamp, input logic [15:0] addr,
                           input logic [7:0] val, input int n_typed, input vgm_cmd_t t0,
                           input vgm_cmd_t t1);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, addr, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_beat(op, stamp, addr, val);
    if (n_typed < 0) begin
      foreach (new_cmds[k]) pending_cmds.push_back(new_cmds[k]);
    end else begin
      if (n_typed > 0) pending_cmds.push_back(t0);
      if (n_typed > 1) pending_cmds.push_back(t1);
    end
    beats_in++;
    if (op == OP_FINISH) finish_beats++;
  endtask

  // Random input-side gap
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h (command beat %0d)", what, got, want,
             cmd_beats);
    err_count++;
  endtask

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      cmd_beats++;
      seen_cmd.cmd    = out_tdata[7:0];
      seen_cmd.arg1   = out_tdata[15:8];
      seen_cmd.arg2   = out_tdata[23:16];
      seen_cmd.nbytes = out_tdata[25:24];
      seen_cmd.total  = out_tdata[57:26];
      seen_cmd.last   = out_tlast;
      if (pending_cmds.size() == 0) begin
        report_mismatch("command with nothing pending", 64'(seen_cmd), 64'd0);
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (seen_cmd.cmd !== want_cmd.cmd)
          report_mismatch("cmd_byte", 64'(seen_cmd.cmd), 64'(want_cmd.cmd));
        if (seen_cmd.arg1 !== want_cmd.arg1)
          report_mismatch("arg_one", 64'(seen_cmd.arg1), 64'(want_cmd.arg1));
        if (seen_cmd.arg2 !== want_cmd.arg2)
          report_mismatch("arg_two", 64'(seen_cmd.arg2), 64'(want_cmd.arg2));
        if (seen_cmd.nbytes !== want_cmd.nbytes)
          report_mismatch("byte_count", 64'(seen_cmd.nbytes), 64'(want_cmd.nbytes));
        if (seen_cmd.total !== want_cmd.total)
          report_mismatch("sample_total", 64'(seen_cmd.total), 64'(want_cmd.total));
        if (seen_cmd.last !== want_cmd.last)
          report_mismatch("tlast", 64'(seen_cmd.last), 64'(want_cmd.last));
        if (out_tdata[63:58] !== 6'd0)
          report_mismatch("tdata pad", 64'(out_tdata[63:58]), 64'd0);
      end
    end
  end

  // Output-side backpressure in random bursts, always ready near the end
  initial begin
    int burst;
    wait (rst_n);
    forever begin
      if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 2) != 0);
        burst = $urandom_range(1, 16);
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d commands still pending", cycle_count,
               pending_cmds.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    vgm_cmd_t    z;
    logic [47:0] cur_stamp;
    logic [47:0] stamp;
    logic [15:0] addr;
    logic [7:0]  val;
    logic        op;
    int          kind;
    z = '0;

    // directed beats: typed commands where they are obvious
    add_row(OP_WRITE, 48'd0, 16'h0000, 8'h00, 0, z, z);  // nothing to emit
    add_row(OP_WRITE, 48'd0, 16'hff10, 8'hff, 1,
            mk_cmd(vrle_pkg::CMD_REG, 8'h00, 8'hff, vrle_pkg::CNT_THREE, 32'd0, 1'b1), z);
    add_row(OP_WRITE, 48'd0, 16'hffff, 8'h00, 1,
            mk_cmd(vrle_pkg::CMD_REG, 8'hef, 8'h00, vrle_pkg::CNT_THREE, 32'd0, 1'b1), z);
    add_row(OP_WRITE, 48'd96, 16'h1234, 8'h55, 1,
            mk_cmd(vrle_pkg::CMD_SHORT, 8'h00, 8'h00, vrle_pkg::CNT_ONE, 32'd0, 1'b1),
            z);                                                             // 1 sample
    add_row(OP_WRITE, 48'd1617, 16'hff0f, 8'haa, 1,
            mk_cmd(8'h7f, 8'h00, 8'h00, vrle_pkg::CNT_ONE, 32'd0, 1'b1), z);  // 16 samples
    add_row(OP_WRITE, 48'd3234, 16'h0000, 8'h00, 1,
            mk_cmd(vrle_pkg::CMD_WAIT, 8'h11, 8'h00, vrle_pkg::CNT_THREE, 32'd0, 1'b1),
            z);                                                             // 17 samples
    add_row(OP_WRITE, 48'd6236198, 16'hff20, 8'h5a, -1, z, z);          // full chunk
    add_row(OP_WRITE, 48'd12472500, 16'h0000, 8'h01, -1, z, z);         // chunk + rest
    add_row(OP_WRITE, 48'd0, 16'hff15, 8'h33, 1,
            mk_cmd(vrle_pkg::CMD_REG, 8'h05, 8'h33, vrle_pkg::CNT_THREE, 32'd0, 1'b1),
            z);                                                             // backward
    add_row(OP_WRITE, 48'hffff_ffff_ffff, 16'hff10, 8'h81, -1, z, z);   // clamped
    add_row(OP_FINISH, 48'd0, 16'h0000, 8'h00, -1, z, z);
    add_row(OP_FINISH, 48'hffff_ffff_ffff, 16'hffff, 8'hff, 2,
            mk_cmd(vrle_pkg::CMD_WAIT, 8'h44, 8'hac, vrle_pkg::CNT_THREE, 32'd0, 1'b0),
            mk_cmd(vrle_pkg::CMD_END, 8'h00, 8'h00, vrle_pkg::CNT_ONE, 32'd0, 1'b1));
    add_row(OP_WRITE, 48'h8000_0000_0000, 16'hfffe, 8'ha5, -1, z, z);
    add_row(OP_WRITE, 48'd1, 16'hff0f, 8'h7e, 0, z, z);                // backward, silent
    add_row(OP_WRITE, 48'h5555_5555_5555, 16'haaaa, 8'h55, -1, z, z);
    add_row(OP_FINISH, 48'h0, 16'h0000, 8'h00, -1, z, z);
    add_row(OP_WRITE, 48'd200, 16'h0000, 8'h00, 1,
            mk_cmd(8'h71, 8'h00, 8'h00, vrle_pkg::CNT_ONE, 32'd0, 1'b1), z);  // 2 samples
    add_row(OP_WRITE, 48'd1700, 16'hff11, 8'h0f, 2,
            mk_cmd(8'h7e, 8'h00, 8'h00, vrle_pkg::CNT_ONE, 32'd0, 1'b0),
            mk_cmd(vrle_pkg::CMD_REG, 8'h01, 8'h0f, vrle_pkg::CNT_THREE, 32'd0, 1'b1));
    add_row(OP_FINISH, 48'd0, 16'h0000, 8'h00, 2,
            mk_cmd(vrle_pkg::CMD_WAIT, 8'h44, 8'hac, vrle_pkg::CNT_THREE, 32'd17, 1'b0),
            mk_cmd(vrle_pkg::CMD_END, 8'h00, 8'h00, vrle_pkg::CNT_ONE, 32'd17, 1'b1));
    add_row(OP_WRITE, 48'd12472500, 16'h0000, 8'h00, -1, z, z);

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      maybe_gap();
      send_beat(dir_rows[i].op, dir_rows[i].stamp, dir_rows[i].addr, dir_rows[i].val,
                dir_rows[i].n_typed, dir_rows[i].t0, dir_rows[i].t1);
    end

    // random beats: mostly forward time steps of assorted size
    cur_stamp = 48'd12472500;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= RANDOM_BEATS - CALM_BEATS);
      kind = $urandom_range(0, 99);
      op   = OP_WRITE;
      val  = 8'($urandom);
      addr = ($urandom_range(0, 1) != 0) ?
             16'($urandom_range(vrle_pkg::REG_BASE, 16'hffff)) : 16'($urandom);
      if (kind < 5) begin
        op        = OP_FINISH;
        stamp     = 48'({$urandom, $urandom});
        cur_stamp = 48'($urandom_range(0, 100000));
      end else if (kind < 10) begin
        stamp = (cur_stamp == 0) ? 48'd0 : 48'({$urandom, $urandom} % 64'(cur_stamp));
      end else if (kind < 13) begin
        stamp = 48'({$urandom, $urandom});
      end else if (kind < 15) begin
        stamp = cur_stamp + 48'h1000_0000 + 48'($urandom);
      end else if (kind < 25) begin
        stamp = cur_stamp;
      end else if (kind < 65) begin
        stamp = cur_stamp + 48'($urandom_range(1, 1700));
      end else if (kind < 90) begin
        stamp = cur_stamp + 48'($urandom_range(1700, 6_300_000));
      end else begin
        stamp = cur_stamp + 48'($urandom_range(6_300_000, 60_000_000));
      end
      if (op == OP_WRITE) cur_stamp = stamp;
      maybe_gap();
      send_beat(op, stamp, addr, val, -1, z, z);
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats (%0d finish), checked %0d command beats", beats_in,
             finish_beats, cmd_beats);
    $display("Writes with clamped wait: %0d, mismatches: %0d", clamped_writes, err_count);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
